FILE: src/mshr_pkg.sv
// Package for the multichannel sample history ring.
// Holds the request and result transfer types, the request kinds and defaults.
// No dependencies.
`default_nettype none

package mshr_pkg;

	// Default sizing of the history store.
	localparam int HISTORY_DEPTH = 64;
	localparam int CHANNELS      = 8;
	localparam int SAMPLE_BITS   = 16;

	// Fixed widths of the transfer fields.
	localparam int SAMPLE_W = 16;
	localparam int INPUTS   = 8;

	// Request kinds.
	typedef enum logic [1:0] {
		KIND_STORE   = 2'd0,
		KIND_HISTORY = 2'd1,
		KIND_LATEST  = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	// One request transfer.
	typedef struct packed {
		kind_t                      kind;
		logic signed [SAMPLE_W-1:0] sample_ch0;
		logic signed [SAMPLE_W-1:0] sample_ch1;
		logic signed [SAMPLE_W-1:0] sample_ch2;
		logic signed [SAMPLE_W-1:0] sample_ch3;
		logic signed [SAMPLE_W-1:0] sample_ch4;
		logic signed [SAMPLE_W-1:0] sample_ch5;
		logic signed [SAMPLE_W-1:0] sample_ch6;
		logic signed [SAMPLE_W-1:0] sample_ch7;
		logic [3:0]                 channel_select;
		logic [6:0]                 want_count;
	} req_item_t;

	// One result transfer.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic [2:0]                 channel_index;
		logic                       last;
		logic [6:0]                 copied_count;
		logic                       ok;
	} rsp_item_t;

endpackage

`default_nettype wire

FILE: src/multichannel_sample_history_ring_core.sv
// Sequential core: store and restart requests act when accepted; a read request holds req_ready
// low from its accepting edge until the cycle after its final result transfer.
// A history request takes its samples in turn, each through the RAM read, load and present states
// on the one RAM read port; latest walks the snapshot channels, a rejected history one result.
// arst_n clears the sequencer, write pointer, frame count and snapshot; the history RAM is not
// cleared, as reads never reach entries unwritten since restart. Uses mshr_pkg and mshr_ram.
`default_nettype none

module multichannel_sample_history_ring_core #(
	parameter int HISTORY_DEPTH = mshr_pkg::HISTORY_DEPTH,
	parameter int CHANNELS      = mshr_pkg::CHANNELS,
	parameter int SAMPLE_BITS   = mshr_pkg::SAMPLE_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire mshr_pkg::req_item_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output mshr_pkg::rsp_item_t      rsp
);

	localparam int PTR_W  = $clog2(HISTORY_DEPTH);
	localparam int HELD_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WORD_W = CHANNELS * SAMPLE_BITS;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_LD   = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [PTR_W-1:0]        wp_q;
	logic [HELD_W-1:0]       held_q;
	logic [SAMPLE_BITS-1:0]  latest_q [CHANNELS];
	logic [PTR_W-1:0]        rd_addr_q;
	logic [HELD_W-1:0]       rem_q;
	logic [HELD_W-1:0]       count_q;
	logic [CH_W-1:0]         ch_q;
	logic                    hist_q;
	mshr_pkg::rsp_item_t     rsp_q;

	logic                    req_fire;
	logic                    rsp_fire;
	logic                    store_fire;
	logic [mshr_pkg::SAMPLE_W-1:0] in_samples [mshr_pkg::INPUTS];
	logic [WORD_W-1:0]       wr_word;
	logic [WORD_W-1:0]       rd_word;
	logic [6:0]              held_ext;
	logic [6:0]              n_ext;
	logic [HELD_W-1:0]       n_hist;
	logic                    bad_sel;
	logic [PTR_W:0]          start_sum;
	logic [PTR_W-1:0]        start_addr;
	logic [PTR_W-1:0]        next_addr;
	logic [CH_W-1:0]         sel_ch;
	logic [CH_W-1:0]         lat_idx;
	logic signed [SAMPLE_BITS-1:0] lat_val;
	logic signed [SAMPLE_BITS-1:0] ram_val;

	assign req_ready  = (state_q == S_IDLE);
	assign rsp_valid  = (state_q == S_OUT);
	assign rsp        = rsp_q;
	assign req_fire   = req_valid & req_ready;
	assign rsp_fire   = rsp_valid & rsp_ready;
	assign store_fire = req_fire & (req.kind == mshr_pkg::KIND_STORE);

	// Gather the frame samples and keep the low bits of each stored channel.
	always_comb begin
		in_samples[0] = req.sample_ch0;
		in_samples[1] = req.sample_ch1;
		in_samples[2] = req.sample_ch2;
		in_samples[3] = req.sample_ch3;
		in_samples[4] = req.sample_ch4;
		in_samples[5] = req.sample_ch5;
		in_samples[6] = req.sample_ch6;
		in_samples[7] = req.sample_ch7;
		for (int c = 0; c < CHANNELS; c++) begin
			wr_word[c*SAMPLE_BITS +: SAMPLE_BITS] = in_samples[c][SAMPLE_BITS-1:0];
		end
	end

	// History request set-up: clamp the count and find the oldest frame to return.
	always_comb begin
		held_ext   = 7'(held_q);
		n_ext      = (req.want_count < held_ext) ? req.want_count : held_ext;
		n_hist     = HELD_W'(n_ext);
		bad_sel    = (req.channel_select == 4'd0) ||
		             (req.channel_select > 4'(CHANNELS));
		sel_ch     = CH_W'(req.channel_select - 4'd1);
		start_sum  = (PTR_W+1)'({1'b0, wp_q}) + (PTR_W+1)'(HISTORY_DEPTH) -
		             (PTR_W+1)'(n_hist);
		if (start_sum >= (PTR_W+1)'(HISTORY_DEPTH)) begin
			start_sum = start_sum - (PTR_W+1)'(HISTORY_DEPTH);
		end
		start_addr = start_sum[PTR_W-1:0];
		next_addr  = (rd_addr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
	end

	// Snapshot and RAM sample selection through one channel mux each.
	assign lat_idx = (state_q == S_IDLE) ? '0 : ch_q + 1'b1;
	assign lat_val = latest_q[lat_idx];
	assign ram_val = rd_word[ch_q*SAMPLE_BITS +: SAMPLE_BITS];

	mshr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk    (clk),
		.wr_en  (store_fire),
		.wr_addr(wp_q),
		.wr_data(wr_word),
		.rd_en  (state_q == S_RD),
		.rd_addr(rd_addr_q),
		.rd_data(rd_word)
	);

	// Ring state: write pointer, clamped frame count and latest-frame snapshot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			held_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				latest_q[c] <= '0;
			end
		end else if (req_fire) begin
			case (req.kind)
				mshr_pkg::KIND_STORE: begin
					wp_q <= (wp_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
					if (held_q != HELD_W'(HISTORY_DEPTH)) begin
						held_q <= held_q + 1'b1;
					end
					for (int c = 0; c < CHANNELS; c++) begin
						latest_q[c] <= wr_word[c*SAMPLE_BITS +: SAMPLE_BITS];
					end
				end
				mshr_pkg::KIND_RESTART: begin
					wp_q   <= '0;
					held_q <= '0;
					for (int c = 0; c < CHANNELS; c++) begin
						latest_q[c] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Read sequencer: walks the history one sample at a time, or the snapshot one channel at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && req.kind == mshr_pkg::KIND_HISTORY) begin
						state_q <= (bad_sel || n_hist == '0) ? S_OUT : S_RD;
					end else if (req_fire && req.kind == mshr_pkg::KIND_LATEST) begin
						state_q <= S_OUT;
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: state_q <= S_OUT;
				S_OUT: begin
					if (rsp_fire) begin
						if (rsp_q.last) begin
							state_q <= S_IDLE;
						end else if (hist_q) begin
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer payload: read address, remaining count, channel and the result register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire && req.kind == mshr_pkg::KIND_HISTORY) begin
					rd_addr_q <= start_addr;
					rem_q     <= n_hist;
					count_q   <= n_hist;
					ch_q      <= sel_ch;
					hist_q    <= 1'b1;
					rsp_q     <= '{sample_value: '0, channel_index: '0, last: 1'b1,
					               copied_count: '0, ok: 1'b0};
				end else if (req_fire && req.kind == mshr_pkg::KIND_LATEST) begin
					ch_q   <= '0;
					hist_q <= 1'b0;
					rsp_q  <= '{sample_value: mshr_pkg::SAMPLE_W'(lat_val),
					            channel_index: '0,
					            last: (CHANNELS == 1),
					            copied_count: 7'(CHANNELS),
					            ok: (held_q != '0)};
				end
			end
			S_LD: begin
				rsp_q <= '{sample_value: mshr_pkg::SAMPLE_W'(ram_val),
				           channel_index: 3'(ch_q),
				           last: (rem_q == HELD_W'(1)),
				           copied_count: 7'(count_q),
				           ok: 1'b1};
				rem_q <= rem_q - 1'b1;
			end
			S_OUT: begin
				if (rsp_fire && !rsp_q.last) begin
					if (hist_q) begin
						rd_addr_q <= next_addr;
					end else begin
						ch_q                <= lat_idx;
						rsp_q.sample_value  <= mshr_pkg::SAMPLE_W'(lat_val);
						rsp_q.channel_index <= 3'(lat_idx);
						rsp_q.last          <= (lat_idx == CH_W'(CHANNELS - 1));
					end
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// The clamped frame count never passes the history depth.
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(HISTORY_DEPTH))
		else $error("frame count above history depth");

	// The read address always names an entry of the history store.
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> rd_addr_q <= PTR_W'(HISTORY_DEPTH - 1))
		else $error("history read address out of range");

	// After a store at least one frame is held.
	a_store_held: assert property (@(posedge clk) disable iff (!arst_n)
		store_fire |=> held_q != '0)
		else $error("store did not count a frame");

	// The final result transfer returns the block to taking requests.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire && rsp.last |=> req_ready)
		else $error("block not ready after final result");

	// A history sample result is only produced while a nonzero count is outstanding.
	a_hist_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LD |-> rem_q != '0)
		else $error("history sample loaded with no samples left");
`endif

endmodule

`default_nettype wire

FILE: src/mshr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module mshr_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
